@@ sv/disk_pair_elastic_collision_defines.svh @@
// Assertion macros for the disk pair collision block
`ifndef DISK_PAIR_ELASTIC_COLLISION_DEFINES_SVH
`define DISK_PAIR_ELASTIC_COLLISION_DEFINES_SVH

// same-cycle implication
`define DPEC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DPEC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/dpec_pkg.sv @@
`timescale 1ns / 1ps

package dpec_pkg;

   localparam int POS_W = 20;
   localparam int VEL_W = 16;
   localparam int RAD_W = 16;
   localparam int DIF_W = POS_W + 1;
   localparam int DV_W  = VEL_W + 1;
   localparam int SQ_W  = 2 * DIF_W - 1;
   localparam int D_W   = SQ_W + 1;
   localparam int P_W   = DV_W + DIF_W;
   localparam int W_W   = P_W + 1;
   localparam int N_W   = W_W + DIF_W;
   localparam int MAG_W = N_W - 1;
   localparam int NUM_W = MAG_W + 2;
   localparam int DEN_W = D_W + 1;
   localparam int QUO_W = 18;
   localparam int REACH_W  = RAD_W + 1;
   localparam int REACH2_W = 2 * REACH_W;

   localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd2560;
   localparam logic [REACH2_W-1:0] REACH2_RESET =
      REACH2_W'(4 * int'(RADIUS_RESET) * int'(RADIUS_RESET));

   localparam logic CSR_IDX_RADIUS = 1'b0;

   typedef struct packed {
      logic             touching;
      logic             exchanged;
      logic             coincident;
      logic             neg_x;
      logic             neg_y;
      logic [VEL_W-1:0] v1x;
      logic [VEL_W-1:0] v1y;
      logic [VEL_W-1:0] v2x;
      logic [VEL_W-1:0] v2y;
   } side_type;

endpackage

@@ sv/dpec_divider.sv @@
`timescale 1ns / 1ps

module dpec_divider #(
   parameter int NUM_W = dpec_pkg::NUM_W,
   parameter int DEN_W = dpec_pkg::DEN_W,
   parameter int QUO_W = dpec_pkg::QUO_W
) (
   input  logic             clock,
   input  logic             advance,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [NUM_W-1:0] rem_in [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];

   // restoring division, one quotient bit per stage, msb first
   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      logic [NUM_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [QUO_W-1:0] quo_src;
      logic [NUM_W-1:0] trial;
      if (i == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign den_src = den_ff[i-1];
         assign quo_src = quo_ff[i-1];
      end
      assign trial = NUM_W'(den_src) << (QUO_W - 1 - i);
      always_comb begin
         if (rem_src >= trial) begin
            rem_in[i] = rem_src - trial;
            quo_in[i] = {quo_src[QUO_W-2:0], 1'b1};
         end else begin
            rem_in[i] = rem_src;
            quo_in[i] = {quo_src[QUO_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i] <= rem_in[i];
            den_ff[i] <= den_src;
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

@@ sv/disk_pair_elastic_collision.sv @@
`timescale 1ns / 1ps
// Fully pipelined: one pair per cycle sustained, while rsp_tready does not hold the output back.
// From req transfer to rsp_tvalid the pipeline runs through 5 arithmetic stages,
// an 18-stage restoring divider (one quotient bit per stage), and one output stage.
// Synchronous active-high reset clears valid bits and sets the radius to 10.0;
// no clearing pass, the block accepts transfers in the cycle after reset.

`include "disk_pair_elastic_collision_defines.svh"

module disk_pair_elastic_collision (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_x, first_y, first_vel_x, first_vel_y,
   // second_x, second_y, second_vel_x, second_vel_y
   input  logic [143:0] req_tdata,
   // repeat_pair
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y
   output logic [63:0]  rsp_tdata,
   // touching, exchanged, coincident
   output logic [2:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int POS_W    = dpec_pkg::POS_W;
   localparam int VEL_W    = dpec_pkg::VEL_W;
   localparam int RAD_W    = dpec_pkg::RAD_W;
   localparam int DIF_W    = dpec_pkg::DIF_W;
   localparam int DV_W     = dpec_pkg::DV_W;
   localparam int SQ_W     = dpec_pkg::SQ_W;
   localparam int D_W      = dpec_pkg::D_W;
   localparam int P_W      = dpec_pkg::P_W;
   localparam int W_W      = dpec_pkg::W_W;
   localparam int N_W      = dpec_pkg::N_W;
   localparam int MAG_W    = dpec_pkg::MAG_W;
   localparam int NUM_W    = dpec_pkg::NUM_W;
   localparam int DEN_W    = dpec_pkg::DEN_W;
   localparam int QUO_W    = dpec_pkg::QUO_W;
   localparam int REACH_W  = dpec_pkg::REACH_W;
   localparam int REACH2_W = dpec_pkg::REACH2_W;

   // config
   logic [RAD_W-1:0]    radius_ff;
   logic [REACH2_W-1:0] reach2_ff;
   logic [REACH_W-1:0]  reach;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == dpec_pkg::CSR_IDX_RADIUS);
   assign reach = {csr_pwdata[RAD_W-1:0], 1'b0};
   assign csr_prdata = (csr_paddr[2] == dpec_pkg::CSR_IDX_RADIUS) ?
                       32'(radius_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= dpec_pkg::RADIUS_RESET;
         reach2_ff <= dpec_pkg::REACH2_RESET;
      end else if (csr_wr) begin
         radius_ff <= csr_pwdata[RAD_W-1:0];
         reach2_ff <= REACH2_W'(reach) * REACH2_W'(reach);
      end
   end

   logic advance;
   logic out_valid_ff;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   logic signed [POS_W-1:0] fx, fy, sx, sy;
   logic [VEL_W-1:0]        fvx, fvy, svx, svy;
   assign fx  = req_tdata[19:0];
   assign fy  = req_tdata[39:20];
   assign fvx = req_tdata[55:40];
   assign fvy = req_tdata[71:56];
   assign sx  = req_tdata[91:72];
   assign sy  = req_tdata[111:92];
   assign svx = req_tdata[127:112];
   assign svy = req_tdata[143:128];

   // stage 1: differences
   logic                    v1_ff;
   logic signed [DIF_W-1:0] s1_dx_ff, s1_dy_ff;
   logic signed [DV_W-1:0]  s1_dvx_ff, s1_dvy_ff;
   logic [VEL_W-1:0]        s1_v1x_ff, s1_v1y_ff, s1_v2x_ff, s1_v2y_ff;
   logic                    s1_rep_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= req_tvalid;
      if (advance) begin
         s1_dx_ff  <= DIF_W'(fx) - DIF_W'(sx);
         s1_dy_ff  <= DIF_W'(fy) - DIF_W'(sy);
         s1_dvx_ff <= $signed({svx[VEL_W-1], svx}) - $signed({fvx[VEL_W-1], fvx});
         s1_dvy_ff <= $signed({svy[VEL_W-1], svy}) - $signed({fvy[VEL_W-1], fvy});
         s1_v1x_ff <= fvx;
         s1_v1y_ff <= fvy;
         s1_v2x_ff <= svx;
         s1_v2y_ff <= svy;
         s1_rep_ff <= req_tuser[0];
      end
   end

   // stage 2: products
   logic                    v2_ff;
   logic [SQ_W-1:0]         s2_dx2_ff, s2_dy2_ff;
   logic signed [P_W-1:0]   s2_px_ff, s2_py_ff;
   logic signed [DIF_W-1:0] s2_dx_ff, s2_dy_ff;
   logic [VEL_W-1:0]        s2_v1x_ff, s2_v1y_ff, s2_v2x_ff, s2_v2y_ff;
   logic                    s2_rep_ff;
   logic signed [2*DIF_W-1:0] sqx, sqy;

   assign sqx = s1_dx_ff * s1_dx_ff;
   assign sqy = s1_dy_ff * s1_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         s2_dx2_ff <= sqx[SQ_W-1:0];
         s2_dy2_ff <= sqy[SQ_W-1:0];
         s2_px_ff  <= s1_dvx_ff * s1_dx_ff;
         s2_py_ff  <= s1_dvy_ff * s1_dy_ff;
         s2_dx_ff  <= s1_dx_ff;
         s2_dy_ff  <= s1_dy_ff;
         s2_v1x_ff <= s1_v1x_ff;
         s2_v1y_ff <= s1_v1y_ff;
         s2_v2x_ff <= s1_v2x_ff;
         s2_v2y_ff <= s1_v2y_ff;
         s2_rep_ff <= s1_rep_ff;
      end
   end

   // stage 3: distance, dot product, flags
   logic                    v3_ff;
   logic [D_W-1:0]          s3_d_ff;
   logic signed [W_W-1:0]   s3_w_ff;
   logic signed [DIF_W-1:0] s3_dx_ff, s3_dy_ff;
   logic [VEL_W-1:0]        s3_v1x_ff, s3_v1y_ff, s3_v2x_ff, s3_v2y_ff;
   logic                    s3_touch_ff, s3_coin_ff, s3_exch_ff;
   logic [D_W-1:0]          dist2;
   logic                    touch, coin;

   assign dist2 = D_W'(s2_dx2_ff) + D_W'(s2_dy2_ff);
   assign touch = dist2 <= D_W'(reach2_ff);
   assign coin  = dist2 == '0;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
      if (advance) begin
         s3_d_ff     <= dist2;
         s3_w_ff     <= W_W'(s2_px_ff) + W_W'(s2_py_ff);
         s3_dx_ff    <= s2_dx_ff;
         s3_dy_ff    <= s2_dy_ff;
         s3_v1x_ff   <= s2_v1x_ff;
         s3_v1y_ff   <= s2_v1y_ff;
         s3_v2x_ff   <= s2_v2x_ff;
         s3_v2y_ff   <= s2_v2y_ff;
         s3_touch_ff <= touch;
         s3_coin_ff  <= coin;
         s3_exch_ff  <= touch && !coin && !s2_rep_ff;
      end
   end

   // stage 4: projected numerators
   logic                  v4_ff;
   logic signed [N_W-1:0] s4_nx_ff, s4_ny_ff;
   logic [D_W-1:0]        s4_d_ff;
   dpec_pkg::side_type    s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
      if (advance) begin
         s4_nx_ff              <= s3_w_ff * s3_dx_ff;
         s4_ny_ff              <= s3_w_ff * s3_dy_ff;
         s4_d_ff               <= s3_d_ff;
         s4_side_ff.touching   <= s3_touch_ff;
         s4_side_ff.exchanged  <= s3_exch_ff;
         s4_side_ff.coincident <= s3_coin_ff;
         s4_side_ff.neg_x      <= 1'b0;
         s4_side_ff.neg_y      <= 1'b0;
         s4_side_ff.v1x        <= s3_v1x_ff;
         s4_side_ff.v1y        <= s3_v1y_ff;
         s4_side_ff.v2x        <= s3_v2x_ff;
         s4_side_ff.v2y        <= s3_v2y_ff;
      end
   end

   // stage 5: magnitudes with rounding bias
   logic               v5_ff;
   logic [NUM_W-1:0]   s5_numx_ff, s5_numy_ff;
   logic [DEN_W-1:0]   s5_den_ff;
   dpec_pkg::side_type s5_side_ff;
   dpec_pkg::side_type s5_side_in;
   logic [N_W-1:0]     absx, absy;

   assign absx = s4_nx_ff[N_W-1] ? N_W'(-s4_nx_ff) : N_W'(s4_nx_ff);
   assign absy = s4_ny_ff[N_W-1] ? N_W'(-s4_ny_ff) : N_W'(s4_ny_ff);

   always_comb begin
      s5_side_in       = s4_side_ff;
      s5_side_in.neg_x = s4_nx_ff[N_W-1];
      s5_side_in.neg_y = s4_ny_ff[N_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (advance) v5_ff <= v4_ff;
      if (advance) begin
         s5_numx_ff <= {absx[MAG_W-1:0], 1'b0} + NUM_W'(s4_d_ff);
         s5_numy_ff <= {absy[MAG_W-1:0], 1'b0} + NUM_W'(s4_d_ff);
         s5_den_ff  <= {s4_d_ff, 1'b0};
         s5_side_ff <= s5_side_in;
      end
   end

   // divider stages
   logic [QUO_W-1:0]   qx, qy;
   logic               dv_ff   [QUO_W];
   dpec_pkg::side_type side_ff [QUO_W];

   dpec_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_x (
      .clock   (clock),
      .advance (advance),
      .num     (s5_numx_ff),
      .den     (s5_den_ff),
      .quo     (qx)
   );

   dpec_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_y (
      .clock   (clock),
      .advance (advance),
      .num     (s5_numy_ff),
      .den     (s5_den_ff),
      .quo     (qy)
   );

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else if (advance) dv_ff[0] <= v5_ff;
      if (advance) side_ff[0] <= s5_side_ff;
      for (int i = 1; i < QUO_W; i++) begin
         if (reset) dv_ff[i] <= 1'b0;
         else if (advance) dv_ff[i] <= dv_ff[i-1];
         if (advance) side_ff[i] <= side_ff[i-1];
      end
   end

   // output stage: apply exchange, saturate
   localparam int SUM_W = QUO_W + 2;

   dpec_pkg::side_type     fs;
   logic signed [QUO_W:0]  sqx_q, sqy_q;
   logic [VEL_W-1:0]       n1x, n1y, n2x, n2y;
   logic [63:0]            out_data_ff;
   logic [2:0]             out_user_ff;

   function automatic logic [VEL_W-1:0] add_sat(input logic [VEL_W-1:0] v,
                                                  input logic signed [QUO_W:0] q,
                                                  input logic sub);
      logic signed [SUM_W-1:0] s;
      logic signed [SUM_W-1:0] vmax;
      logic signed [SUM_W-1:0] vmin;
      vmax = SUM_W'(2 ** (VEL_W - 1) - 1);
      vmin = -SUM_W'(2 ** (VEL_W - 1));
      if (sub) s = SUM_W'($signed(v)) - SUM_W'(q);
      else     s = SUM_W'($signed(v)) + SUM_W'(q);
      if (s > vmax)      add_sat = vmax[VEL_W-1:0];
      else if (s < vmin) add_sat = vmin[VEL_W-1:0];
      else               add_sat = s[VEL_W-1:0];
   endfunction

   assign fs    = side_ff[QUO_W-1];
   assign sqx_q = fs.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
   assign sqy_q = fs.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

   always_comb begin
      if (fs.exchanged) begin
         n1x = add_sat(fs.v1x, sqx_q, 1'b0);
         n1y = add_sat(fs.v1y, sqy_q, 1'b0);
         n2x = add_sat(fs.v2x, sqx_q, 1'b1);
         n2y = add_sat(fs.v2y, sqy_q, 1'b1);
      end else begin
         n1x = fs.v1x;
         n1y = fs.v1y;
         n2x = fs.v2x;
         n2y = fs.v2y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (advance) out_valid_ff <= dv_ff[QUO_W-1];
      if (advance) begin
         out_data_ff <= {n2y, n2x, n1y, n1x};
         out_user_ff <= {fs.coincident, fs.exchanged, fs.touching};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   `DPEC_ASSERT_NOW(a_exch_needs_touch, rsp_tvalid && rsp_tuser[1], rsp_tuser[0] && !rsp_tuser[2], "exchange without a distinct touching pair")
   `DPEC_ASSERT_NOW(a_coin_is_touch, rsp_tvalid && rsp_tuser[2], rsp_tuser[0], "coincident pair not flagged touching")
   `DPEC_ASSERT_NOW(a_stall_only_on_hold, !req_tready, rsp_tvalid && !rsp_tready, "input stalled without output back-pressure")
   `DPEC_ASSERT_NEXT(a_hold_output, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

class collision_scoreboard;
   typedef struct {
      logic [2:0]  flags;
      logic [63:0] vels;
   } outcome_type;

   outcome_type pending[$];
   bit [15:0] radius;
   int errors;
   int seen;
   int exchanges;
   int touches;

   function new();
      radius = 16'd2560;
   endfunction

   function logic [15:0] sat16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function longint div_nearest(longint n, longint d);
      longint mag;
      longint q;
      mag = (n < 0) ? -n : n;
      q = (2 * mag + d) / (2 * d);
      return (n < 0) ? -q : q;
   endfunction

   function void note_pair(logic [143:0] data, logic rep);
      longint x1, y1, vx1, vy1, x2, y2, vx2, vy2, dx, dy, dist2, reach, w, qx, qy;
      bit touch, coinc, exch;
      outcome_type o;
      x1  = $signed(data[19:0]);
      y1  = $signed(data[39:20]);
      vx1 = $signed(data[55:40]);
      vy1 = $signed(data[71:56]);
      x2  = $signed(data[91:72]);
      y2  = $signed(data[111:92]);
      vx2 = $signed(data[127:112]);
      vy2 = $signed(data[143:128]);
      dx = x1 - x2;
      dy = y1 - y2;
      dist2 = dx * dx + dy * dy;
      reach = 2 * longint'(radius);
      touch = dist2 <= reach * reach;
      coinc = dist2 == 0;
      exch = touch && !coinc && !rep;
      if (exch) begin
         w = (vx2 - vx1) * dx + (vy2 - vy1) * dy;
         qx = div_nearest(w * dx, dist2);
         qy = div_nearest(w * dy, dist2);
         vx1 += qx;
         vy1 += qy;
         vx2 -= qx;
         vy2 -= qy;
      end
      o.flags = {coinc, exch, touch};
      o.vels = {sat16(vy2), sat16(vx2), sat16(vy1), sat16(vx1)};
      pending.insert(pending.size(), o);
   endfunction

   function bit check_result(logic [63:0] data, logic [2:0] flags, output string why);
      outcome_type o;
      seen++;
      if (pending.size() == 0) begin
         why = "result transfer with nothing expected";
         return 0;
      end
      o = pending.pop_front();
      touches += flags[0];
      exchanges += flags[1];
      if (flags !== o.flags) begin
         why = $sformatf("flags got %b want %b", flags, o.flags);
         return 0;
      end
      if (data !== o.vels) begin
         why = $sformatf("velocities got %h want %h", data, o.vels);
         return 0;
      end
      return 1;
   endfunction
endclass

module tb;

   localparam int LATENCY = 24;
   localparam int RANDOM_ITEMS = 2000;
   localparam longint LIMIT = 400000;
   localparam logic [2:0] ADDR_RADIUS = {dpec_pkg::CSR_IDX_RADIUS, 2'b00};

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [63:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_psel = 0;
   logic         csr_penable = 0;
   logic         csr_pwrite = 0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   collision_scoreboard board = new();
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   longint cycles = 0;

   disk_pair_elastic_collision u_dut (.*);

   always #6 clock = ~clock;

   task automatic report(string why);
      mismatches++;
      $display("MISMATCH at cycle %0d: %s", cycles, why);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      string why;
      if (!reset && rsp_tvalid && rsp_tready)
         if (!board.check_result(rsp_tdata, rsp_tuser, why)) report(why);
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_radius(logic [15:0] r);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= ADDR_RADIUS;
      csr_pwdata <= {16'd0, r};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      board.radius = r;
   endtask

   task automatic send_pair(logic [19:0] x1, logic [19:0] y1, logic [15:0] vx1,
                            logic [15:0] vy1, logic [19:0] x2, logic [19:0] y2,
                            logic [15:0] vx2, logic [15:0] vy2, logic rep);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {vy2, vx2, y2, x2, vy1, vx1, y1, x1};
      req_tuser <= rep;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_pair({vy2, vx2, y2, x2, vy1, vx1, y1, x1}, rep);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic random_pair(int span);
      logic [19:0] x1, y1, ox, oy;
      int mode;
      mode = $urandom_range(9);
      x1 = 20'($urandom);
      y1 = 20'($urandom);
      if (mode < 7) begin
         ox = 20'(int'($urandom_range(2 * span)) - span);
         oy = 20'(int'($urandom_range(2 * span)) - span);
      end else begin
         ox = 20'($urandom);
         oy = 20'($urandom);
      end
      if (mode == 9) begin
         ox = 0;
         oy = 0;
      end
      send_pair(x1, y1, 16'($urandom), 16'($urandom), x1 - ox, y1 - oy,
                16'($urandom), 16'($urandom), $urandom_range(5) == 0);
   endtask

   initial begin
      int span;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners at reset radius
      send_pair(20'h80000, 20'h80000, 16'h8000, 16'h8000,
                20'h7ffff, 20'h7ffff, 16'h7fff, 16'h7fff, 0);
      send_pair(20'h7ffff, 20'h80000, 16'h7fff, 16'h8000,
                20'h80000, 20'h7ffff, 16'h8000, 16'h7fff, 0);
      send_pair(20'd100, 20'd100, 16'h0100, 16'h0000,
                20'd100, 20'd100, 16'hff00, 16'h0000, 0);
      send_pair(20'd0, 20'd0, 16'h0100, 16'h0000,
                20'd1000, 20'd0, 16'hff00, 16'h0000, 0);
      send_pair(20'd0, 20'd0, 16'h0100, 16'h0000,
                20'd1000, 20'd0, 16'hff00, 16'h0000, 1);
      send_pair(20'd0, 20'd0, 16'h0100, 16'h0200,
                20'd5120, 20'd0, 16'hff00, 16'h0000, 0);
      send_pair(20'd0, 20'd0, 16'h0100, 16'h0200,
                20'd5121, 20'd0, 16'hff00, 16'h0000, 0);
      send_pair(20'd0, 20'd0, 16'h8000, 16'h8000,
                20'd300, 20'd300, 16'h7fff, 16'h7fff, 0);
      send_pair(20'd0, 20'd0, 16'h7fff, 16'h7fff,
                20'd1, 20'd1, 16'h8000, 16'h8000, 0);
      send_pair(20'd3, 20'd0, 16'h0001, 16'h0000,
                20'd0, 20'd2, 16'h0000, 16'h0003, 0);
      drain();

      write_radius(16'd0);
      send_pair(20'd5, 20'd5, 16'd1, 16'd2, 20'd5, 20'd5, 16'd3, 16'd4, 0);
      send_pair(20'd5, 20'd5, 16'd1, 16'd2, 20'd6, 20'd5, 16'd3, 16'd4, 0);
      drain();
      write_radius(16'hffff);
      send_pair(20'h80000, 20'h80000, 16'h1234, 16'h8000,
                20'h7ffff, 20'h7ffff, 16'h7fff, 16'hedcb, 0);
      send_pair(20'h00000, 20'h00000, 16'h7fff, 16'h8000,
                20'h7ffff, 20'h7ffff, 16'h8000, 16'h7fff, 0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0: begin send_idle_pct = 36; recv_idle_pct = 50; end
            1: begin send_idle_pct = 50; recv_idle_pct = 36; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (phase)
            0: write_radius(16'd2560);
            1: write_radius(16'd1);
            2: write_radius(16'($urandom_range(16'hffff)));
            3: write_radius(16'hffff);
            4: write_radius(16'($urandom_range(4000, 200)));
            default: write_radius(16'd0);
         endcase
         span = 4 * board.radius + 8;
         if (span > 500000) span = 500000;
         for (int i = 0; i < RANDOM_ITEMS / 6; i++) random_pair(span);
         drain();
      end

      $display("covered %0d pair transfers, %0d touching, %0d exchanges, six radius settings",
               board.seen, board.touches, board.exchanges);
      if (mismatches == 0 && board.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
